### src/bvbm_pkg.sv
package bvbm_pkg;

	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_ASSET_COUNT   = 3'd0;
	localparam logic [2:0] REG_INCOME_COUNT  = 3'd1;
	localparam logic [2:0] REG_PERIOD_COUNT  = 3'd2;
	localparam logic [2:0] REG_DISCOUNT      = 3'd3;
	localparam logic [2:0] REG_MISSING_VALUE = 3'd4;

	localparam logic [15:0] DISCOUNT_RESET = 16'd62259;
	localparam logic [31:0] MISSING_RESET  = 32'hFF9D_0000;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	localparam logic       FUNC_GRID = 1'b0;
	localparam logic       FUNC_CASH = 1'b1;

	localparam int SQ_STEPS = 16;

	typedef struct packed {
		logic        restart;
		logic [6:0]  asset_count;
		logic [4:0]  income_count;
		logic [7:0]  period_count;
		logic [15:0] discount;
		logic [31:0] missing_value;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

endpackage

### src/bvbm_cfg.sv
module bvbm_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bvbm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output bvbm_pkg::cfg_t              cfg
);

	logic [6:0]  asset_count_q;
	logic [4:0]  income_count_q;
	logic [7:0]  period_count_q;
	logic [15:0] discount_q;
	logic [31:0] missing_value_q;
	logic        restart_q;
	logic        wr_en;
	logic [2:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asset_count_q   <= 7'd1;
			income_count_q  <= 5'd1;
			period_count_q  <= 8'd1;
			discount_q      <= bvbm_pkg::DISCOUNT_RESET;
			missing_value_q <= bvbm_pkg::MISSING_RESET;
			restart_q       <= 1'b0;
		end else begin
			restart_q <= 1'b0;
			if (wr_en) begin
				unique case (reg_idx)
					bvbm_pkg::REG_ASSET_COUNT: begin
						asset_count_q <= pwdata[6:0];
						restart_q     <= 1'b1;
					end
					bvbm_pkg::REG_INCOME_COUNT: begin
						income_count_q <= pwdata[4:0];
						restart_q      <= 1'b1;
					end
					bvbm_pkg::REG_PERIOD_COUNT: begin
						period_count_q <= pwdata[7:0];
						restart_q      <= 1'b1;
					end
					bvbm_pkg::REG_DISCOUNT: begin
						discount_q <= pwdata[15:0];
					end
					bvbm_pkg::REG_MISSING_VALUE: begin
						missing_value_q <= pwdata;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		unique case (reg_idx)
			bvbm_pkg::REG_ASSET_COUNT:   prdata = {25'd0, asset_count_q};
			bvbm_pkg::REG_INCOME_COUNT:  prdata = {27'd0, income_count_q};
			bvbm_pkg::REG_PERIOD_COUNT:  prdata = {24'd0, period_count_q};
			bvbm_pkg::REG_DISCOUNT:      prdata = {16'd0, discount_q};
			bvbm_pkg::REG_MISSING_VALUE: prdata = missing_value_q;
			default:                     prdata = 32'd0;
		endcase
	end

	assign cfg.restart       = restart_q;
	assign cfg.asset_count   = asset_count_q;
	assign cfg.income_count  = income_count_q;
	assign cfg.period_count  = period_count_q;
	assign cfg.discount      = discount_q;
	assign cfg.missing_value = missing_value_q;

endmodule

### src/bvbm_cand.sv
module bvbm_cand (
	input  logic                clk,
	input  logic                arst_n,
	input  bvbm_pkg::tag_t      tag_in,
	input  logic                final_mode,
	input  logic signed [31:0]  cash,
	input  logic signed [31:0]  grid,
	input  logic signed [31:0]  vnext,
	input  logic [15:0]         discount,
	output bvbm_pkg::tag_t      tag_out,
	output logic                w_feasible,
	output logic signed [33:0]  w
);

	localparam int N = bvbm_pkg::SQ_STEPS;

	bvbm_pkg::tag_t     tag_s2;
	logic signed [32:0] c_s2;
	logic signed [48:0] prod_s2;

	bvbm_pkg::tag_t     tag_sq_s  [N+1];
	logic               feas_sq_s [N+1];
	logic [30:0]        m_sq_s    [N+1];
	logic [15:0]        frac_sq_s [N+1];
	logic [4:0]         k_sq_s    [N+1];
	logic signed [31:0] vt_sq_s   [N+1];

	logic [31:0]        x_b;
	logic [4:0]         k_b;
	logic [30:0]        m_b;
	logic               feas_b;
	logic signed [31:0] vsel;

	bvbm_pkg::tag_t     tag_s20;
	logic               feas_s20;
	logic               neg_s20;
	logic [53:0]        prod_s20;
	logic signed [31:0] vt_s20;

	bvbm_pkg::tag_t     tag_s21;
	logic               feas_s21;
	logic signed [33:0] w_s21;

	logic signed [21:0] l_fin;
	logic [21:0]        mag_fin;
	logic [54:0]        rnd;
	logic signed [33:0] ln_val;

	assign vsel = final_mode ? 32'sd0 : vnext;

	always_ff @(posedge clk) begin
		if (final_mode) begin
			c_s2 <= {cash[31], cash};
		end else begin
			c_s2 <= {cash[31], cash} - {grid[31], grid};
		end
		prod_s2 <= vsel * $signed({1'b0, discount});
	end

	always_comb begin
		x_b    = c_s2[31:0];
		feas_b = !c_s2[32] && (c_s2 != 33'sd0);
		k_b    = 5'd0;
		for (int b = 1; b < 32; b++) begin
			if (x_b[b]) begin
				k_b = 5'(b);
			end
		end
		if (k_b == 5'd31) begin
			m_b = x_b[31:1];
		end else begin
			m_b = 31'(x_b << (5'd30 - k_b));
		end
	end

	always_ff @(posedge clk) begin
		feas_sq_s[0] <= feas_b;
		m_sq_s[0]    <= m_b;
		frac_sq_s[0] <= 16'd0;
		k_sq_s[0]    <= k_b;
		vt_sq_s[0]   <= prod_s2[47:16];
	end

	for (genvar i = 0; i < N; i++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] t;
		logic [30:0] m_next;
		logic [15:0] fr_next;

		always_comb begin
			sq      = 62'(m_sq_s[i]) * 62'(m_sq_s[i]);
			t       = sq[61:30];
			fr_next = frac_sq_s[i];
			if (t[31]) begin
				m_next            = t[31:1];
				fr_next[N-1-i]    = 1'b1;
			end else begin
				m_next = t[30:0];
			end
		end

		always_ff @(posedge clk) begin
			feas_sq_s[i+1] <= feas_sq_s[i];
			m_sq_s[i+1]    <= m_next;
			frac_sq_s[i+1] <= fr_next;
			k_sq_s[i+1]    <= k_sq_s[i];
			vt_sq_s[i+1]   <= vt_sq_s[i];
		end
	end

	always_comb begin
		l_fin   = $signed({6'({1'b0, k_sq_s[N]} - 6'd16), frac_sq_s[N]});
		mag_fin = l_fin[21] ? 22'(-l_fin) : 22'(l_fin);
		rnd     = {1'b0, prod_s20} + 55'h0_0000_8000_0000;
		if (neg_s20) begin
			ln_val = -$signed({12'd0, rnd[53:32]});
		end else begin
			ln_val = $signed({12'd0, rnd[53:32]});
		end
	end

	always_ff @(posedge clk) begin
		feas_s20 <= feas_sq_s[N];
		neg_s20  <= l_fin[21];
		prod_s20 <= 54'(mag_fin) * 54'(bvbm_pkg::LN2_Q32);
		vt_s20   <= vt_sq_s[N];
		feas_s21 <= feas_s20;
		w_s21    <= ln_val + 34'(vt_s20);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2  <= '0;
			tag_s20 <= '0;
			tag_s21 <= '0;
			for (int j = 0; j <= N; j++) begin
				tag_sq_s[j] <= '0;
			end
		end else begin
			tag_s2      <= tag_in;
			tag_sq_s[0] <= tag_s2;
			for (int j = 0; j < N; j++) begin
				tag_sq_s[j+1] <= tag_sq_s[j];
			end
			tag_s20 <= tag_sq_s[N];
			tag_s21 <= tag_s20;
		end
	end

	assign tag_out    = tag_s21;
	assign w_feasible = feas_s21;
	assign w          = w_s21;

endmodule

### src/bellman_value_backward_max.sv
// Each cash item evaluates one candidate per savings grid point, or a single candidate
// in the final period. The block takes one cash item at a time; the savings scan reads
// one grid point per cycle from the grid and value memories, followed by a drain of the
// logarithm pipeline and result selection, and the next item is taken only after the
// result of the last one has been registered for output.
// Reset clears the positions and the bank select and
// starts a new run at the final period; the memories are not cleared.
module bellman_value_backward_max #(
	parameter int MAX_ASSETS  = 64,
	parameter int MAX_INCOME  = 16,
	parameter int MAX_PERIODS = 255
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bvbm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [5:0]                  grid_index,
	input  logic signed [31:0]          amount,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [31:0]          value,
	output logic                        infeasible,
	output logic [5:0]                  asset_index,
	output logic [3:0]                  income_index,
	output logic [7:0]                  period
);

	localparam int AW     = $clog2(MAX_ASSETS);
	localparam int ACW    = $clog2(MAX_ASSETS + 1);
	localparam int IW     = (MAX_INCOME > 1) ? $clog2(MAX_INCOME) : 1;
	localparam int ICW    = $clog2(MAX_INCOME + 1);
	localparam int PW     = $clog2(MAX_PERIODS + 1);
	localparam int BANK   = MAX_ASSETS * MAX_INCOME;
	localparam int VDEPTH = 2 * BANK;
	localparam int VAW    = $clog2(VDEPTH);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	bvbm_pkg::cfg_t cfg;

	state_t             state_q;
	logic [AW-1:0]      asset_pos_q;
	logic [IW-1:0]      income_pos_q;
	logic [PW-1:0]      period_pos_q;
	logic               bank_q;
	logic [ACW-1:0]     iss_q;
	logic signed [31:0] cash_q;
	logic               final_q;
	logic [PW-1:0]      per_q;
	logic signed [33:0] best_q;
	logic               any_q;

	logic               out_valid_q;
	logic signed [31:0] value_q;
	logic               infeasible_q;
	logic [AW-1:0]      asset_index_q;
	logic [IW-1:0]      income_index_q;
	logic [PW-1:0]      period_q;

	logic [31:0]        grid_mem [MAX_ASSETS];
	logic [31:0]        vbank_mem [VDEPTH];
	logic signed [31:0] grid_rd_s1;
	logic signed [31:0] vb_rd_s1;
	bvbm_pkg::tag_t     tag_s1;

	logic [ACW-1:0]     na;
	logic [ICW-1:0]     ny;
	logic [PW-1:0]      np;
	logic [PW-1:0]      pp;
	logic               in_xfer;
	logic               cash_xfer;
	logic               grid_we;
	logic               issue_last;
	logic [VAW-1:0]     rd_addr;
	logic [VAW-1:0]     wr_addr;
	logic               finish;
	logic signed [31:0] result;
	logic               last_asset;
	logic               last_income;

	bvbm_pkg::tag_t     w_tag;
	logic               w_feasible;
	logic signed [33:0] w;

	bvbm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	always_comb begin
		if (cfg.asset_count == 7'd0) begin
			na = ACW'(1);
		end else if (32'(cfg.asset_count) > 32'(MAX_ASSETS)) begin
			na = ACW'(MAX_ASSETS);
		end else begin
			na = ACW'(cfg.asset_count);
		end
		if (cfg.income_count == 5'd0) begin
			ny = ICW'(1);
		end else if (32'(cfg.income_count) > 32'(MAX_INCOME)) begin
			ny = ICW'(MAX_INCOME);
		end else begin
			ny = ICW'(cfg.income_count);
		end
		if (cfg.period_count == 8'd0) begin
			np = PW'(1);
		end else if (32'(cfg.period_count) > 32'(MAX_PERIODS)) begin
			np = PW'(MAX_PERIODS);
		end else begin
			np = PW'(cfg.period_count);
		end
		if (period_pos_q == '0 || period_pos_q > np) begin
			pp = np;
		end else begin
			pp = period_pos_q;
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign in_xfer    = in_valid && !in_stall;
	assign cash_xfer  = in_xfer && (func == bvbm_pkg::FUNC_CASH);
	assign grid_we    = in_xfer && (func == bvbm_pkg::FUNC_GRID)
		&& (32'(grid_index) < 32'(MAX_ASSETS));
	assign issue_last = final_q || (iss_q == na - ACW'(1));
	assign finish     = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign result     = !any_q ? $signed(cfg.missing_value)
		: (best_q > 34'sd2147483647)  ? 32'sh7FFF_FFFF
		: (best_q < -34'sd2147483648) ? 32'sh8000_0000
		: 32'(best_q);
	assign last_asset  = (ACW'(asset_pos_q) + ACW'(1)) >= na;
	assign last_income = (ICW'(income_pos_q) + ICW'(1)) >= ny;

	assign rd_addr = VAW'(32'(!bank_q) * 32'(BANK) + 32'(income_pos_q) * 32'(MAX_ASSETS)
		+ 32'(iss_q[AW-1:0]));
	assign wr_addr = VAW'(32'(bank_q) * 32'(BANK) + 32'(income_pos_q) * 32'(MAX_ASSETS)
		+ 32'(asset_pos_q));

	always_ff @(posedge clk) begin
		if (grid_we) begin
			grid_mem[grid_index[AW-1:0]] <= amount;
		end
		grid_rd_s1 <= grid_mem[iss_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			vbank_mem[wr_addr] <= result;
		end
		vb_rd_s1 <= vbank_mem[rd_addr];
	end

	bvbm_cand u_cand (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_in    (tag_s1),
		.final_mode(final_q),
		.cash      (cash_q),
		.grid      (grid_rd_s1),
		.vnext     (vb_rd_s1),
		.discount  (cfg.discount),
		.tag_out   (w_tag),
		.w_feasible(w_feasible),
		.w         (w)
	);

	always_ff @(posedge clk) begin
		if (cash_xfer) begin
			cash_q  <= amount;
			final_q <= (pp == np);
			per_q   <= pp;
		end
		if (finish) begin
			value_q        <= result;
			infeasible_q   <= !any_q;
			asset_index_q  <= asset_pos_q;
			income_index_q <= income_pos_q;
			period_q       <= per_q;
		end
		if (cash_xfer) begin
			any_q <= 1'b0;
		end else if (w_tag.valid && w_feasible && (!any_q || w > best_q)) begin
			any_q  <= 1'b1;
			best_q <= w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			asset_pos_q  <= '0;
			income_pos_q <= '0;
			period_pos_q <= '0;
			bank_q       <= 1'b0;
			iss_q        <= '0;
			tag_s1       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			tag_s1.valid <= (state_q == ST_SCAN);
			tag_s1.last  <= (state_q == ST_SCAN) && issue_last;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.restart) begin
				asset_pos_q  <= '0;
				income_pos_q <= '0;
				period_pos_q <= '0;
				bank_q       <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cash_xfer) begin
						iss_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					iss_q <= iss_q + ACW'(1);
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (w_tag.valid && w_tag.last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (last_asset) begin
							asset_pos_q <= '0;
							if (last_income) begin
								income_pos_q <= '0;
								bank_q       <= !bank_q;
								period_pos_q <= per_q - PW'(1);
							end else begin
								income_pos_q <= income_pos_q + IW'(1);
								period_pos_q <= per_q;
							end
						end else begin
							asset_pos_q  <= asset_pos_q + AW'(1);
							period_pos_q <= per_q;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign value        = value_q;
	assign infeasible   = infeasible_q;
	assign asset_index  = 6'(asset_index_q);
	assign income_index = 4'(income_index_q);
	assign period       = 8'(period_q);

	a_cand_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		w_tag.valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("Candidate result outside a scan.");

	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> !w_tag.valid && !tag_s1.valid)
		else $error("Pipeline still busy when the item completes.");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("Result transfer raised without a completed item.");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> iss_q < na)
		else $error("Scan index beyond the savings grid.");

endmodule

### sim/bellman_value_backward_max_checker.sv
`timescale 1ns / 100ps

module bellman_value_backward_max_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               func,
	input  logic [5:0]         grid_index,
	input  logic signed [31:0] amount,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] value,
	input  logic               infeasible,
	input  logic [5:0]         asset_index,
	input  logic [3:0]         income_index,
	input  logic [7:0]         period,
	output int                 errors,
	output int                 pending
);

	localparam int NA_MAX = 64;
	localparam int NY_MAX = 16;
	localparam int NP_MAX = 255;
	localparam longint unsigned LN2 = 64'd2977044472;

	typedef struct {
		logic signed [31:0] value;
		logic               infeasible;
		logic [5:0]         asset_index;
		logic [3:0]         income_index;
		logic [7:0]         period;
	} state_value_t;

	state_value_t value_queue[$];

	logic [6:0]  asset_reg;
	logic [4:0]  income_reg;
	logic [7:0]  period_reg;
	logic [15:0] beta;
	logic [31:0] na_value;
	longint      savings[NA_MAX];
	longint      banks[2][NY_MAX][NA_MAX];
	int          apos, ypos, ppos;
	bit          bank;

	assign pending = value_queue.size();

	function automatic int clamp_count(int v, int hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic longint ln_q16(longint unsigned x);
		int k;
		longint unsigned m, mag, r;
		longint l;
		k = 0;
		while (k < 63 && (x >> (k + 1)) != 0)
			k++;
		m = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
		l = longint'(k - 16) * 65536;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				l += longint'(1) << (15 - i);
			end
		end
		mag = (l < 0) ? longint'(-l) : l;
		r = (mag * LN2 + (64'd1 << 31)) >> 32;
		return (l < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint discounted(longint v);
		longint p;
		p = v * longint'({48'd0, beta});
		return p >>> 16;
	endfunction

	task automatic restart_run();
		apos = 0;
		ypos = 0;
		bank = 0;
		ppos = clamp_count(period_reg, NP_MAX);
	endtask

	task automatic predict_cash(logic signed [31:0] cash_in);
		int na, ny, np;
		longint cash, c, w, best;
		bit none;
		state_value_t e;
		na = clamp_count(asset_reg, NA_MAX);
		ny = clamp_count(income_reg, NY_MAX);
		np = clamp_count(period_reg, NP_MAX);
		cash = cash_in;
		best = 0;
		none = 1;
		if (apos >= na)
			apos = 0;
		if (ypos >= ny)
			ypos = 0;
		if (ppos == 0 || ppos > np)
			ppos = np;
		if (ppos == np) begin
			if (cash > 0) begin
				best = ln_q16(cash);
				none = 0;
			end
		end else begin
			for (int s = 0; s < na; s++) begin
				c = cash - savings[s];
				if (c > 0) begin
					w = ln_q16(c) + discounted(banks[!bank][ypos][s]);
					if (none || w > best)
						best = w;
					none = 0;
				end
			end
		end
		if (none)
			best = longint'(signed'(na_value));
		else if (best > 64'sd2147483647)
			best = 64'sd2147483647;
		else if (best < -64'sd2147483648)
			best = -64'sd2147483648;
		banks[bank][ypos][apos] = best;
		e.value = best[31:0];
		e.infeasible = none;
		e.asset_index = apos[5:0];
		e.income_index = ypos[3:0];
		e.period = ppos[7:0];
		value_queue.push_back(e);
		apos++;
		if (apos >= na) begin
			apos = 0;
			ypos++;
			if (ypos >= ny) begin
				ypos = 0;
				bank = !bank;
				ppos--;
				if (ppos == 0)
					ppos = np;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		state_value_t e;
		if (!arst_n) begin
			asset_reg = 1;
			income_reg = 1;
			period_reg = 1;
			beta = bvbm_pkg::DISCOUNT_RESET;
			na_value = bvbm_pkg::MISSING_RESET;
			errors = 0;
			value_queue.delete();
			restart_run();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
				bvbm_pkg::REG_ASSET_COUNT: begin
					asset_reg = pwdata[6:0];
					restart_run();
				end
				bvbm_pkg::REG_INCOME_COUNT: begin
					income_reg = pwdata[4:0];
					restart_run();
				end
				bvbm_pkg::REG_PERIOD_COUNT: begin
					period_reg = pwdata[7:0];
					restart_run();
				end
				bvbm_pkg::REG_DISCOUNT: beta = pwdata[15:0];
				bvbm_pkg::REG_MISSING_VALUE: na_value = pwdata;
				default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (value_queue.size() == 0) begin
					$error("result transfer with no expectation waiting");
					errors++;
				end else begin
					e = value_queue.pop_front();
					if (value !== e.value) begin
						$error("value: expected %0d, got %0d", e.value, value);
						errors++;
					end
					if (infeasible !== e.infeasible) begin
						$error("infeasible: expected %0d, got %0d", e.infeasible, infeasible);
						errors++;
					end
					if (asset_index !== e.asset_index) begin
						$error("asset_index: expected %0d, got %0d", e.asset_index,
							asset_index);
						errors++;
					end
					if (income_index !== e.income_index) begin
						$error("income_index: expected %0d, got %0d", e.income_index,
							income_index);
						errors++;
					end
					if (period !== e.period) begin
						$error("period: expected %0d, got %0d", e.period, period);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (func == bvbm_pkg::FUNC_GRID)
					savings[grid_index] = longint'(amount);
				else
					predict_cash(amount);
			end
		end
	end

endmodule

### sim/bellman_value_backward_max_tb.sv
`timescale 1ns / 100ps

module bellman_value_backward_max_tb;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int RANDOM_ITEMS = 1650;
	localparam int DRAIN_CYCLES = 120;

	logic                        clk;
	logic                        arst_n;
	logic                        psel, penable, pwrite;
	logic [bvbm_pkg::ADDR_W-1:0] paddr;
	logic [31:0]                 pwdata, prdata;
	logic                        pready;
	logic                        in_valid, in_stall, func;
	logic [5:0]                  grid_index;
	logic signed [31:0]          amount;
	logic                        out_valid, out_stall;
	logic signed [31:0]          value;
	logic                        infeasible;
	logic [5:0]                  asset_index;
	logic [3:0]                  income_index;
	logic [7:0]                  period;
	int                          errors, pending;
	int                          cycles;
	int                          cash_sent, phases;
	int                          stall_left;
	bit                          idling;

	bellman_value_backward_max u_top (.*);

	bellman_value_backward_max_checker u_checker (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("bellman_value_backward_max_tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			stall_left = idling ? $urandom_range(0, 4) : 0;
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send(logic f, logic [5:0] idx, logic [31:0] amt);
		int gap;
		gap = idling ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		grid_index <= idx;
		amount <= amt;
		do @(posedge clk); while (in_stall);
		if (f == bvbm_pkg::FUNC_CASH)
			cash_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] cash_value();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return $urandom_range(0, 40 << 16) - (1 << 16);
	endfunction

	function automatic logic [31:0] saving_value();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return $urandom_range(0, 12 << 16) - (2 << 16);
	endfunction

	initial begin
		int na_reg, ny_reg, np_reg, na, ny, np, items;
		clk = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		in_valid = 0;
		func = bvbm_pkg::FUNC_GRID;
		grid_index = '0;
		amount = '0;
		out_stall = 0;
		cycles = 0;
		cash_sent = 0;
		phases = 0;
		stall_left = 0;
		idling = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int g = 0; g < 64; g++)
			send(bvbm_pkg::FUNC_GRID, g[5:0], saving_value());
		send(bvbm_pkg::FUNC_GRID, 6'd0, 32'h8000_0000);
		send(bvbm_pkg::FUNC_GRID, 6'd1, 32'h7FFF_FFFF);
		settle();
		reg_write(bvbm_pkg::REG_ASSET_COUNT, 32'd2);
		reg_write(bvbm_pkg::REG_PERIOD_COUNT, 32'd3);
		send(bvbm_pkg::FUNC_CASH, 6'd0, 32'd0);
		send(bvbm_pkg::FUNC_CASH, 6'd0, 32'h7FFF_FFFF);
		send(bvbm_pkg::FUNC_CASH, 6'd0, 32'h8000_0000);
		send(bvbm_pkg::FUNC_CASH, 6'd0, 32'd1);
		send(bvbm_pkg::FUNC_CASH, 6'd0, 32'h7FFF_FFFF);
		send(bvbm_pkg::FUNC_CASH, 6'd0, 32'hFFFF_FFFF);
		send(bvbm_pkg::FUNC_CASH, 6'd0, 32'd1);
		settle();

		cash_sent = 0;
		while (cash_sent < RANDOM_ITEMS) begin
			phases++;
			idling = (phases % 4) != 3;
			case ($urandom_range(0, 5))
			0: na_reg = 0;
			1: na_reg = 127;
			2: na_reg = 64;
			default: na_reg = $urandom_range(1, 6);
			endcase
			case ($urandom_range(0, 5))
			0: ny_reg = 0;
			1: ny_reg = 31;
			2: ny_reg = 16;
			default: ny_reg = $urandom_range(1, 3);
			endcase
			np_reg = $urandom_range(1, 4);
			na = (na_reg == 0) ? 1 : (na_reg > 64 ? 64 : na_reg);
			if (na * ((ny_reg == 0) ? 1 : (ny_reg > 16 ? 16 : ny_reg)) > 48)
				ny_reg = $urandom_range(0, 1);
			if ($urandom_range(0, 9) == 0) begin
				na_reg = 1;
				ny_reg = 1;
				np_reg = $urandom_range(0, 1) ? 255 : 0;
			end
			na = (na_reg == 0) ? 1 : (na_reg > 64 ? 64 : na_reg);
			ny = (ny_reg == 0) ? 1 : (ny_reg > 16 ? 16 : ny_reg);
			np = (np_reg == 0) ? 1 : np_reg;
			reg_write(bvbm_pkg::REG_ASSET_COUNT, na_reg);
			reg_write(bvbm_pkg::REG_INCOME_COUNT, ny_reg);
			reg_write(bvbm_pkg::REG_PERIOD_COUNT, np_reg);
			case ($urandom_range(0, 4))
			0: reg_write(bvbm_pkg::REG_DISCOUNT, 32'd0);
			1: reg_write(bvbm_pkg::REG_DISCOUNT, 32'd65535);
			default: reg_write(bvbm_pkg::REG_DISCOUNT, $urandom_range(40000, 65535));
			endcase
			case ($urandom_range(0, 4))
			0: reg_write(bvbm_pkg::REG_MISSING_VALUE, 32'h8000_0000);
			1: reg_write(bvbm_pkg::REG_MISSING_VALUE, 32'h7FFF_FFFF);
			default: reg_write(bvbm_pkg::REG_MISSING_VALUE, $urandom);
			endcase
			for (int g = 0; g < na; g++)
				send(bvbm_pkg::FUNC_GRID, g[5:0], saving_value());
			items = na * ny * np + $urandom_range(0, 3);
			for (int i = 0; i < items; i++) begin
				if ($urandom_range(0, 11) == 0)
					send(bvbm_pkg::FUNC_GRID, 6'($urandom_range(0, 63)), saving_value());
				send(bvbm_pkg::FUNC_CASH, 6'($urandom_range(0, 63)), cash_value());
			end
			settle();
		end

		$display("Covered %0d configuration phases and %0d random cash transfers", phases,
			cash_sent);
		$display("after a directed run over the amount extremes.");
		if (errors == 0)
			$display("bellman_value_backward_max_tb: done, clean");
		else
			$display("bellman_value_backward_max_tb: done, errors");
		$finish;
	end

endmodule
